>>> rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue package
// Payload types and the link shared by the cells of the sorting chain.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DataW = 32;
	localparam int PriW  = 8;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                    command;
		logic signed [DataW-1:0] item_data;
		logic [PriW-1:0]         item_priority;
	} req_t;

	typedef struct packed {
		logic signed [DataW-1:0] popped_data;
		logic                    popped_valid;
		logic                    pop_on_empty;
		logic                    push_dropped;
		logic signed [DataW-1:0] head_data;
		logic [PriW-1:0]         head_priority;
		logic                    queue_empty;
		logic                    queue_full;
	} rsp_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                    push;
		logic                    pop;
		logic signed [DataW-1:0] data;
		logic [PriW-1:0]         pri;
	} cell_op_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		logic signed [DataW-1:0] data;
		logic [PriW-1:0]         pri;
		logic                    keep;
	} cell_link_t;

endpackage

>>> rtl/core/spq_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface spq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue cell
// One slot of the sorted chain: holds, shifts in from a neighbor or
// captures the pushed entry.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  cell_op_t   op,
	input  logic       occupied,
	input  cell_link_t left,
	input  cell_link_t right,
	output cell_link_t self
);

	logic signed [DataW-1:0] data_q;
	logic [PriW-1:0]         pri_q;
	logic                    keep;

	// An occupied cell whose priority is not above the new one stays put,
	// which keeps entries of equal priority in arrival order.
	assign keep = occupied && (pri_q <= op.pri);

	always_ff @(posedge clk) begin
		if (op.push && !keep) begin
			if (left.keep) begin
				data_q <= op.data;
				pri_q  <= op.pri;
			end else begin
				data_q <= left.data;
				pri_q  <= left.pri;
			end
		end else if (op.pop) begin
			data_q <= right.data;
			pri_q  <= right.pri;
		end
	end

	assign self.data = data_q;
	assign self.pri  = pri_q;
	assign self.keep = keep;

endmodule

>>> rtl/core/stable_priority_queue_top.sv
`timescale 1ns / 1ps
// Result: registered, and presented in the cycle after its command transfer.
// Throughput: one command per cycle while the result register is empty or
// being taken; the cell chain updates every slot in the cycle of the
// transfer and the result register is reloaded while it is being taken.
// Reset: arst_n clears the entry count and the result valid; slot contents
// are not reset and are read only below the entry count.
// ----------------------------------------------------------------------------
// Stable priority queue top level
// Sorted shift chain of DEPTH cells with a registered result stage.
// ----------------------------------------------------------------------------
module stable_priority_queue_top
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	spq_stream_if.sink   req,
	spq_stream_if.source rsp
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic [CntW-1:0] count_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	cell_op_t   op;
	cell_link_t link [DEPTH];
	cell_link_t head_link;
	logic       fire;
	logic       is_empty;
	logic       is_full;
	logic       do_push;
	logic       do_pop;
	rsp_t       rsp_d;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CntW'(DEPTH));
	assign do_push   = fire && (req.payload.command == CMD_PUSH) && !is_full;
	assign do_pop    = fire && (req.payload.command == CMD_POP) && !is_empty;

	assign op.push = do_push;
	assign op.pop  = do_pop;
	assign op.data = req.payload.item_data;
	assign op.pri  = req.payload.item_priority;

	// The head cell sees a virtual left neighbor that always holds.
	assign head_link.data = req.payload.item_data;
	assign head_link.pri  = req.payload.item_priority;
	assign head_link.keep = 1'b1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_link_t left_in;
		cell_link_t right_in;
		if (i == 0) begin : g_first
			assign left_in = head_link;
		end else begin : g_left
			assign left_in = link[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_in = link[i];
		end else begin : g_right
			assign right_in = link[i+1];
		end
		spq_cell u_cell (
			.clk      (clk),
			.op       (op),
			.occupied (CntW'(i) < count_q),
			.left     (left_in),
			.right    (right_in),
			.self     (link[i])
		);
	end

	// Result: outcome of the command and the head after it.
	always_comb begin
		rsp_d               = '0;
		rsp_d.head_data     = link[0].data;
		rsp_d.head_priority = link[0].pri;
		rsp_d.queue_empty   = is_empty;
		rsp_d.queue_full    = is_full;
		if (req.payload.command == CMD_PUSH) begin
			if (is_full) begin
				rsp_d.push_dropped = 1'b1;
			end else begin
				rsp_d.queue_empty = 1'b0;
				rsp_d.queue_full  = (count_q == CntW'(DEPTH - 1));
				if (is_empty || (req.payload.item_priority < link[0].pri)) begin
					rsp_d.head_data     = req.payload.item_data;
					rsp_d.head_priority = req.payload.item_priority;
				end
			end
		end else begin
			if (is_empty) begin
				rsp_d.pop_on_empty = 1'b1;
			end else begin
				rsp_d.popped_data   = link[0].data;
				rsp_d.popped_valid  = 1'b1;
				rsp_d.queue_full    = 1'b0;
				rsp_d.queue_empty   = (count_q == CntW'(1));
				rsp_d.head_data     = link[1].data;
				rsp_d.head_priority = link[1].pri;
			end
		end
		if (rsp_d.queue_empty) begin
			rsp_d.head_data     = '1;
			rsp_d.head_priority = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (do_push) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop) begin
				count_q <= count_q - CntW'(1);
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

>>> rtl/core/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
	import spq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_payload
);

	// A stalled result must hold until its transfer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("result changed while stalled");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.queue_empty |->
			(rsp_payload.head_data == -32'sd1) && (rsp_payload.head_priority == '0))
		else $error("empty queue reports a head entry");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({rsp_payload.popped_valid, rsp_payload.pop_on_empty,
			rsp_payload.push_dropped}))
		else $error("conflicting outcome flags");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_payload.queue_full && rsp_payload.queue_empty))
		else $error("queue both full and empty");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.pop_on_empty |-> rsp_payload.queue_empty &&
			(rsp_payload.popped_data == '0))
		else $error("pop on empty with a non-empty queue");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

>>> sim/stable_priority_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Drives push and pop commands through the request channel and checks every
// response against a software copy of the sorted queue or, for known rows,
// the table's result. A short table of directed commands covers the empty,
// full and equal priority cases; random phases fill and drain the queue.
// ----------------------------------------------------------------------------
module stable_priority_queue_top_test;
	import spq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT   = 500;
	localparam int MAX_ROWS     = 32;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_CYCLIC
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_stream_if #(.payload_t(req_t)) req_if ();
	spq_stream_if #(.payload_t(rsp_t)) rsp_if ();

	stable_priority_queue_top #(.DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Software copy of the queue contents, slot 0 is the head.
	logic signed [DataW-1:0] shadow_data [DEPTH];
	logic [PriW-1:0]         shadow_pri [DEPTH];
	int                      shadow_count;

	rsp_t pending_results[$];
	int   error_count;
	int   n_push, n_pop, n_drop, n_empty_pop, n_checked;

	// Directed stimulus table.
	req_t row_req [MAX_ROWS];
	bit   row_known [MAX_ROWS];
	rsp_t row_rsp [MAX_ROWS];
	int   n_rows;

	int burst_left;
	int idle_cycles;

	function automatic rsp_t sorted_queue_step(input req_t r);
		rsp_t o;
		int   pos;
		int   i;
		o = '0;
		if (r.command == CMD_PUSH) begin
			if (shadow_count >= DEPTH) begin
				o.push_dropped = 1'b1;
				n_drop++;
			end else begin
				// Equal priorities go behind the stored ones to keep arrival order.
				pos = 0;
				while (pos < shadow_count && shadow_pri[pos] <= r.item_priority)
					pos++;
				for (i = shadow_count; i > pos; i--) begin
					shadow_data[i] = shadow_data[i-1];
					shadow_pri[i]  = shadow_pri[i-1];
				end
				shadow_data[pos] = r.item_data;
				shadow_pri[pos]  = r.item_priority;
				shadow_count++;
			end
			n_push++;
		end else begin
			if (shadow_count == 0) begin
				o.pop_on_empty = 1'b1;
				n_empty_pop++;
			end else begin
				o.popped_data  = shadow_data[0];
				o.popped_valid = 1'b1;
				for (i = 0; i + 1 < shadow_count; i++) begin
					shadow_data[i] = shadow_data[i+1];
					shadow_pri[i]  = shadow_pri[i+1];
				end
				shadow_count--;
			end
			n_pop++;
		end
		o.head_data     = (shadow_count == 0) ? '1 : shadow_data[0];
		o.head_priority = (shadow_count == 0) ? '0 : shadow_pri[0];
		o.queue_empty   = (shadow_count == 0);
		o.queue_full    = (shadow_count >= DEPTH);
		return o;
	endfunction

	function automatic req_t push_cmd(input logic [DataW-1:0] d, input logic [PriW-1:0] p);
		req_t r;
		r.command       = CMD_PUSH;
		r.item_data     = d;
		r.item_priority = p;
		return r;
	endfunction

	function automatic req_t pop_cmd();
		req_t r;
		r = '0;
		r.command = CMD_POP;
		return r;
	endfunction

	function automatic rsp_t make_rsp(input logic [DataW-1:0] popped, input logic pv,
			input logic poe, input logic pd, input logic [DataW-1:0] head,
			input logic [PriW-1:0] hp, input logic empty, input logic full);
		rsp_t o;
		o.popped_data   = popped;
		o.popped_valid  = pv;
		o.pop_on_empty  = poe;
		o.push_dropped  = pd;
		o.head_data     = head;
		o.head_priority = hp;
		o.queue_empty   = empty;
		o.queue_full    = full;
		return o;
	endfunction

	task automatic add_row(input req_t r, input bit known, input rsp_t e);
		row_req[n_rows]   = r;
		row_known[n_rows] = known;
		row_rsp[n_rows]   = e;
		n_rows++;
	endtask

	// Sender works in bursts; between bursts valid may drop for a random gap.
	task automatic send_cmd(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
			repeat (gap) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		req_if.valid   <= 1'b1;
		req_if.payload <= r;
		do
			@(posedge clk);
		while (!req_if.ready);
		burst_left--;
	endtask

	task automatic issue(input req_t r, input bit known, input rsp_t e);
		rsp_t predicted;
		predicted = sorted_queue_step(r);
		pending_results.push_back(known ? e : predicted);
		send_cmd(r);
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
			error_count++;
		end
	endtask

	// Response checker.
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.payload;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response transfer, expected none, actual %h",
					$realtime, got);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("popped_data", want.popped_data, got.popped_data);
				compare_field("popped_valid", 32'(want.popped_valid), 32'(got.popped_valid));
				compare_field("pop_on_empty", 32'(want.pop_on_empty), 32'(got.pop_on_empty));
				compare_field("push_dropped", 32'(want.push_dropped), 32'(got.push_dropped));
				compare_field("head_data", want.head_data, got.head_data);
				compare_field("head_priority", 32'(want.head_priority),
					32'(got.head_priority));
				compare_field("queue_empty", 32'(want.queue_empty), 32'(got.queue_empty));
				compare_field("queue_full", 32'(want.queue_full), 32'(got.queue_full));
				n_checked++;
			end
		end
	end

	// Receiver back-pressure, switching between patterns every so often.
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_phase = 0;

	initial rsp_if.ready = 1'b0;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 120);
		end else begin
			rx_left--;
		end
		rx_phase++;
		case (rx_mode)
			RX_OPEN:   rsp_if.ready <= 1'b1;
			RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
			default:   rsp_if.ready <= (rx_phase % 4 != 0);
		endcase
	end

	// Watchdog: ends the run when neither channel has moved for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
		$display("stable_priority_queue_top_test failed");
		$finish;
	end

	initial begin
		req_t r;
		int   rnd_sent;
		int   seg_len;
		int   push_pct;
		int   pri_style;
		int   k;
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		error_count    = 0;
		n_push         = 0;
		n_pop          = 0;
		n_drop         = 0;
		n_empty_pop    = 0;
		n_checked      = 0;
		n_rows         = 0;
		burst_left     = 0;
		shadow_count   = 0;
		for (k = 0; k < DEPTH; k++) begin
			shadow_data[k] = '0;
			shadow_pri[k]  = '0;
		end

		// Empty queue, extremes of data and priority, ties and the all-ones head.
		add_row(pop_cmd(), 1'b1, make_rsp(32'h0000_0000, 1'b0, 1'b1, 1'b0,
			32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0));
		add_row(push_cmd(32'h7FFF_FFFF, 8'd255), 1'b1,
			make_rsp(32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF, 8'd255, 1'b0, 1'b0));
		add_row(push_cmd(32'h8000_0000, 8'd0), 1'b1,
			make_rsp(32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h8000_0000, 8'd0, 1'b0, 1'b0));
		add_row(push_cmd(32'h0000_0005, 8'd0), 1'b1,
			make_rsp(32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h8000_0000, 8'd0, 1'b0, 1'b0));
		add_row(pop_cmd(), 1'b1, make_rsp(32'h8000_0000, 1'b1, 1'b0, 1'b0,
			32'h0000_0005, 8'd0, 1'b0, 1'b0));
		add_row(pop_cmd(), 1'b1, make_rsp(32'h0000_0005, 1'b1, 1'b0, 1'b0,
			32'h7FFF_FFFF, 8'd255, 1'b0, 1'b0));
		add_row(pop_cmd(), 1'b1, make_rsp(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0,
			32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0));
		add_row(push_cmd(32'hFFFF_FFFF, 8'd128), 1'b1,
			make_rsp(32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 8'd128, 1'b0, 1'b0));
		// Fill to DEPTH and push once more, with mixed and repeated priorities.
		add_row(push_cmd(32'hAAAA_AAAA, 8'd3), 1'b0, '0);
		add_row(push_cmd(32'h5555_5555, 8'd128), 1'b0, '0);
		add_row(push_cmd(32'h0000_0001, 8'd200), 1'b0, '0);
		add_row(push_cmd(32'h0000_0002, 8'd3), 1'b0, '0);
		add_row(push_cmd(32'h0000_0003, 8'd0), 1'b0, '0);
		add_row(push_cmd(32'h0000_0004, 8'd255), 1'b0, '0);
		add_row(push_cmd(32'h1234_5678, 8'd128), 1'b0, '0);
		add_row(push_cmd(32'hDEAD_BEEF, 8'd0), 1'b0, '0);
		add_row(push_cmd(32'h8000_0001, 8'd64), 1'b0, '0);
		add_row(push_cmd(32'h7FFF_FFFE, 8'd64), 1'b0, '0);
		add_row(push_cmd(32'h0F0F_0F0F, 8'd1), 1'b0, '0);
		add_row(push_cmd(32'hF0F0_F0F0, 8'd254), 1'b0, '0);
		add_row(push_cmd(32'h0000_0000, 8'd3), 1'b0, '0);
		add_row(push_cmd(32'hCAFE_F00D, 8'd127), 1'b0, '0);
		add_row(push_cmd(32'h0BAD_C0DE, 8'd0), 1'b0, '0);
		add_row(push_cmd(32'h3C3C_3C3C, 8'd10), 1'b0, '0);
		add_row(pop_cmd(), 1'b0, '0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < n_rows; k++)
			issue(row_req[k], row_known[k], row_rsp[k]);

		// Random phases, each leaning toward filling, draining or holding level.
		rnd_sent = 0;
		while (rnd_sent < RANDOM_ITEMS) begin
			seg_len = $urandom_range(20, 80);
			case ($urandom_range(0, 3))
				0:       push_pct = 80;
				1:       push_pct = 20;
				2:       push_pct = 50;
				default: push_pct = 65;
			endcase
			pri_style = $urandom_range(0, 2);
			for (k = 0; k < seg_len && rnd_sent < RANDOM_ITEMS; k++) begin
				r.command = ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP;
				if ($urandom_range(0, 15) == 0) begin
					case ($urandom_range(0, 3))
						0:       r.item_data = 32'h8000_0000;
						1:       r.item_data = 32'h7FFF_FFFF;
						2:       r.item_data = 32'hFFFF_FFFF;
						default: r.item_data = 32'h0000_0000;
					endcase
				end else begin
					r.item_data = $urandom;
				end
				case (pri_style)
					0:       r.item_priority = 8'($urandom_range(0, 3));
					1:       r.item_priority = 8'($urandom_range(0, 255));
					default: begin
						case ($urandom_range(0, 3))
							0:       r.item_priority = 8'd0;
							1:       r.item_priority = 8'd255;
							2:       r.item_priority = 8'd127;
							default: r.item_priority = 8'd128;
						endcase
					end
				endcase
				issue(r, 1'b0, '0);
				rnd_sent++;
			end
		end

		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Checked %0d responses: %0d pushes (%0d dropped on a full queue),",
			n_checked, n_push, n_drop);
		$display("%0d pops (%0d on an empty queue), %0d field errors.",
			n_pop, n_empty_pop, error_count);
		if (error_count == 0)
			$display("stable_priority_queue_top_test passed");
		else
			$display("stable_priority_queue_top_test failed");
		$finish;
	end

endmodule
